[design/rrdp_pkg.sv]
// Shared types and command codes for the reactive robot drive policy.
package rrdp_pkg;

    localparam int SPEED_W = 16;
    localparam int HOLD_W  = 5;
    localparam int THR_W   = 12;
    localparam int DELAY_W = 4;
    localparam int ADDR_W  = 5;
    localparam int FUNC_W  = 6;
    localparam int CODE_W  = ADDR_W + FUNC_W;

    localparam logic [THR_W-1:0]   EDGE_THR_RESET = 12'd3000;
    localparam logic [THR_W-1:0]   DIST_THR_RESET = 12'd2000;
    localparam logic [THR_W-1:0]   DIST_STEP      = 12'd100;
    localparam logic [THR_W-1:0]   DIST_RAISE_MAX = 12'd3900;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 4'd5;
    localparam logic [DELAY_W-1:0] DELAY_RAISE_MAX = 4'd10;
    localparam logic [DELAY_W-1:0] DELAY_LOWER_MIN = 4'd1;
    localparam int                 SPEED_STEP     = 1000;

    localparam logic [ADDR_W-1:0] ADDR_SETUP = 5'd0;

    typedef enum logic [FUNC_W-1:0] {
        FN_DIST_DOWN  = 6'd50,
        FN_DIST_UP    = 6'd51,
        FN_DELAY_DOWN = 6'd54,
        FN_DELAY_UP   = 6'd55,
        FN_SPIN_CCW   = 6'd58,
        FN_SPIN_CW    = 6'd59,
        FN_SPEED_DOWN = 6'd60,
        FN_SPEED_UP   = 6'd61
    } func_t;

    typedef struct packed {
        logic               is_drive;
        logic [SPEED_W-1:0] right_speed;
        logic               right_reverse;
        logic [SPEED_W-1:0] left_speed;
        logic               left_reverse;
        logic [HOLD_W-1:0]  hold_units;
        logic               last;
    } result_t;

endpackage

[design/reactive_robot_drive_policy.sv]
// Drive policy: snapshot or remote request in, one or two timed drive commands out.
// The first result follows a request through the input register and then the result register.
// Throughput: one request per cycle for single-result requests while m_tready is high; edge
//   escapes with back-off give two results and hold the result register until both are taken.
// Reset (rst_n low, asynchronous): all queues empty, edge threshold 3000, speed max/4,
//   delay 5, distance threshold 2000, clockwise spin.
module reactive_robot_drive_policy #(
    parameter int SAMPLE_BITS = 12,
    parameter int SPEED_BITS  = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // edge_front_left, edge_front_right, edge_back_left, edge_back_right,
    // dist_front_left, dist_front_right, dist_back_left, dist_back_right,
    // front_mid_seen, back_mid_seen, started, remote_code, zero padding
    input  logic [((8*SAMPLE_BITS+rrdp_pkg::CODE_W+3+7)/8)*8-1:0] s_tdata,
    // mode
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // right_speed, right_reverse, left_speed, left_reverse, hold_units, zero padding
    output logic [39:0] m_tdata,
    // is_drive
    output logic m_tuser,
    output logic m_tlast,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [rrdp_pkg::THR_W-1:0] cfg_data
);
    import rrdp_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int USED_W = 8*SB + CODE_W + 3;
    localparam int CMP_W  = (SB > THR_W) ? SB : THR_W;
    localparam int SUM_W  = ((SPEED_BITS > 10) ? SPEED_BITS : 10) + 1;
    localparam logic [SUM_W-1:0] SPEED_MAX  = SUM_W'((1 << SPEED_BITS) - 1);
    localparam logic [SUM_W-1:0] SPEED_INC  = SUM_W'(SPEED_STEP);
    localparam logic [SPEED_BITS-1:0] SPEED_RESET = SPEED_BITS'(((1 << SPEED_BITS) - 1) >> 2);

    logic                  in_vld_reg;
    logic [USED_W-1:0]     in_data_reg;
    logic                  in_mode_reg;
    logic                  out_vld_reg;
    result_t               out_reg;
    logic                  pend_vld_reg;
    result_t               pend_reg;
    logic [THR_W-1:0]      edge_thr_reg;
    logic [SPEED_BITS-1:0] base_speed_reg;
    logic [SPEED_BITS-1:0] base_speed_next;
    logic [DELAY_W-1:0]    delay_reg;
    logic [DELAY_W-1:0]    delay_next;
    logic [THR_W-1:0]      dist_thr_reg;
    logic [THR_W-1:0]      dist_thr_next;
    logic                  spin_ccw_reg;
    logic                  spin_ccw_next;

    logic    fire;
    result_t r0;
    result_t r1;
    logic    two;

    assign fire      = in_vld_reg && (!out_vld_reg || (m_tready && !pend_vld_reg));
    assign s_tready  = !in_vld_reg || fire;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.is_drive;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {1'b0, out_reg.hold_units, out_reg.left_reverse, out_reg.left_speed,
                       out_reg.right_reverse, out_reg.right_speed};

    always_comb
    begin
        logic [CMP_W-1:0]      e_thr;
        logic [CMP_W-1:0]      d_thr;
        logic                  efl, efr, ebl, ebr, dfl, dfr, dbl, dbr, fm, bm;
        logic [SPEED_W-1:0]    v;
        logic [SPEED_W-1:0]    h;
        logic [HOLD_W-1:0]     d;
        logic [HOLD_W-1:0]     d2;
        logic [CODE_W-1:0]     code;
        logic [ADDR_W-1:0]     addr;
        logic [FUNC_W-1:0]     func;
        logic [SUM_W-1:0]      base_ext;
        logic [SUM_W-1:0]      sum_up;
        logic                  rev;

        e_thr = CMP_W'(edge_thr_reg);
        d_thr = CMP_W'(dist_thr_reg);
        efl = CMP_W'(in_data_reg[0*SB +: SB]) < e_thr;
        efr = CMP_W'(in_data_reg[1*SB +: SB]) < e_thr;
        ebl = CMP_W'(in_data_reg[2*SB +: SB]) < e_thr;
        ebr = CMP_W'(in_data_reg[3*SB +: SB]) < e_thr;
        dfl = CMP_W'(in_data_reg[4*SB +: SB]) > d_thr;
        dfr = CMP_W'(in_data_reg[5*SB +: SB]) > d_thr;
        dbl = CMP_W'(in_data_reg[6*SB +: SB]) > d_thr;
        dbr = CMP_W'(in_data_reg[7*SB +: SB]) > d_thr;
        fm  = in_data_reg[8*SB];
        bm  = in_data_reg[8*SB+1];
        code = in_data_reg[8*SB+3 +: CODE_W];
        addr = code[CODE_W-1:FUNC_W];
        func = code[FUNC_W-1:0];

        v  = SPEED_W'(base_speed_reg);
        h  = SPEED_W'(base_speed_reg >> 1);
        d  = HOLD_W'(delay_reg);
        d2 = {delay_reg, 1'b0};
        rev = 1'b0;

        base_ext = SUM_W'(base_speed_reg);
        sum_up   = base_ext + SPEED_INC;

        base_speed_next = base_speed_reg;
        delay_next      = delay_reg;
        dist_thr_next   = dist_thr_reg;
        spin_ccw_next   = spin_ccw_reg;

        r0  = '0;
        r1  = '0;
        two = 1'b0;
        r0.is_drive = 1'b1;
        r0.last     = 1'b1;
        r1.is_drive = 1'b1;
        r1.last     = 1'b1;
        r1.right_speed = v;
        r1.left_speed  = v;
        r1.hold_units  = d;

        if (in_mode_reg)
        begin
            r0.is_drive = 1'b0;
            if (addr == ADDR_SETUP)
            begin
                case (func)
                    FN_SPIN_CCW:   spin_ccw_next = 1'b1;
                    FN_SPIN_CW:    spin_ccw_next = 1'b0;
                    FN_SPEED_UP:
                    begin
                        if (sum_up <= SPEED_MAX)
                            base_speed_next = SPEED_BITS'(sum_up);
                    end
                    FN_SPEED_DOWN:
                    begin
                        if (base_ext > SPEED_INC)
                            base_speed_next = SPEED_BITS'(base_ext - SPEED_INC);
                    end
                    FN_DELAY_UP:
                    begin
                        if (delay_reg <= DELAY_RAISE_MAX)
                            delay_next = delay_reg + 4'd1;
                    end
                    FN_DELAY_DOWN:
                    begin
                        if (delay_reg > DELAY_LOWER_MIN)
                            delay_next = delay_reg - 4'd1;
                    end
                    FN_DIST_DOWN:
                    begin
                        if (dist_thr_reg >= DIST_STEP)
                            dist_thr_next = dist_thr_reg - DIST_STEP;
                    end
                    FN_DIST_UP:
                    begin
                        if (dist_thr_reg <= DIST_RAISE_MAX)
                            dist_thr_next = dist_thr_reg + DIST_STEP;
                    end
                    default: ;
                endcase
            end
        end
        else if (!in_data_reg[8*SB+2])
        begin
            // stop command: keep all zero fields
        end
        else
        begin
            r0.right_speed = v;
            r0.left_speed  = v;
            if (efr && efl)
            begin
                r0.right_reverse = 1'b1;
                r0.left_reverse  = 1'b1;
                r0.hold_units    = d;
            end
            else if (ebr && ebl)
            begin
                r0.hold_units = d;
            end
            else if (efl || ebr || efr || ebl)
            begin
                two = 1'b1;
                rev = (efl || ebr) ? efl : efr;
                r0.right_reverse = rev;
                r0.left_reverse  = rev;
                r0.hold_units    = d2;
                r0.last          = 1'b0;
                r1.right_reverse = efl || ebr;
                r1.left_reverse  = !(efl || ebr);
            end
            else if ((dfr && dfl) || fm)
            begin
                // forward at base speed
            end
            else if ((dbr && dbl) || bm)
            begin
                r0.right_reverse = 1'b1;
                r0.left_reverse  = 1'b1;
            end
            else if (dfr || dfl)
            begin
                if (dfl)
                begin
                    r0.left_speed = h;
                    spin_ccw_next = 1'b1;
                end
                else
                begin
                    r0.right_speed = h;
                    spin_ccw_next  = 1'b0;
                end
            end
            else if (dbr || dbl)
            begin
                r0.right_reverse = 1'b1;
                r0.left_reverse  = 1'b1;
                if (dbl)
                begin
                    r0.left_speed = h;
                    spin_ccw_next = 1'b0;
                end
                else
                begin
                    r0.right_speed = h;
                    spin_ccw_next  = 1'b1;
                end
            end
            else
            begin
                r0.right_reverse = !spin_ccw_reg;
                r0.left_reverse  = spin_ccw_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            pend_vld_reg   <= 1'b0;
            edge_thr_reg   <= EDGE_THR_RESET;
            base_speed_reg <= SPEED_RESET;
            delay_reg      <= DELAY_RESET;
            dist_thr_reg   <= DIST_THR_RESET;
            spin_ccw_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                edge_thr_reg <= cfg_data;

            if (s_tvalid && s_tready)
                in_vld_reg <= 1'b1;
            else if (fire)
                in_vld_reg <= 1'b0;

            if (fire)
            begin
                out_vld_reg    <= 1'b1;
                pend_vld_reg   <= two;
                base_speed_reg <= base_speed_next;
                delay_reg      <= delay_next;
                dist_thr_reg   <= dist_thr_next;
                spin_ccw_reg   <= spin_ccw_next;
            end
            else if (out_vld_reg && m_tready)
            begin
                out_vld_reg  <= pend_vld_reg;
                pend_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[USED_W-1:0];
            in_mode_reg <= s_tuser;
        end
        if (fire)
        begin
            out_reg  <= r0;
            pend_reg <= r1;
        end
        else if (out_vld_reg && m_tready && pend_vld_reg)
        begin
            out_reg <= pend_reg;
        end
    end

    // second result only waits behind a shown first result that is not final
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (out_vld_reg && !out_reg.last && out_reg.is_drive))
        else $error("pending result without open first result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (delay_reg >= DELAY_LOWER_MIN) && (delay_reg <= DELAY_RAISE_MAX + 4'd1))
        else $error("delay out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        dist_thr_reg <= DIST_RAISE_MAX + DIST_STEP)
        else $error("distance threshold out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_vld_reg && m_tready) |=> (out_vld_reg && out_reg.last && !pend_vld_reg))
        else $error("pending result not advanced");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!in_vld_reg && !fire) |=> $stable(spin_ccw_reg) && $stable(base_speed_reg))
        else $error("state changed without a request");

endmodule
